// File: src/sai_pkg.sv
// shared constants, types and weight tables for the spectrum autorange interpolator
// no dependencies; imported by the core and the port checker
package sai_pkg;

  // window of frames kept in the range history, and significant level bits
  localparam int WINDOW_LEN  = 40;
  localparam int LEVEL_BITS  = 12;

  // fixed field widths of the item
  localparam int FIELD_W     = 12;
  localparam int CHAN_W      = 12;
  localparam int BAND_COUNT  = 5;
  localparam int CHAN_COUNT  = 10;

  // derived widths
  localparam int BAND_W      = LEVEL_BITS + 1;
  localparam int SLOT_W      = $clog2(WINDOW_LEN);
  localparam int FILL_W      = $clog2(WINDOW_LEN + 1);
  localparam int NUM_W       = BAND_W + CHAN_W;
  localparam int STEP_W      = $clog2(CHAN_W);
  localparam int BIDX_W      = $clog2(BAND_COUNT);
  localparam int CIDX_W      = $clog2(CHAN_COUNT);
  localparam int HIST_W      = 2 * BAND_W;
  localparam int IN_DATA_W   = ((BAND_COUNT * FIELD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((CHAN_COUNT * CHAN_W + 7) / 8) * 8;

  // weighted term: mapped level (< 2^12) times a weight of at most 8
  localparam int WPROD_W     = CHAN_W + 3;
  // shared multiplier operand width
  localparam int MUL_W       = (BAND_W > WPROD_W) ? BAND_W : WPROD_W;

  // divide by nine as multiply by ceil(2^18/9) and shift, exact below 2^15
  localparam int RECIP_SHIFT = 18;
  localparam logic [MUL_W-1:0] RECIP_9 = MUL_W'(((1 << RECIP_SHIFT) + 8) / 9);

  // full scale after reset
  localparam logic [CHAN_W-1:0] FS_RESET = CHAN_W'(1275);

  // only the low LEVEL_BITS bits of a band count
  localparam logic [FIELD_W-1:0] LEVEL_MASK = FIELD_W'((64'd1 << LEVEL_BITS) - 64'd1);

  // ninths weights for channels 1..8, lower and upper neighbor band
  localparam logic [3:0] WT_LO [8] = '{4'd5, 4'd1, 4'd6, 4'd2, 4'd7, 4'd3, 4'd8, 4'd4};
  localparam logic [3:0] WT_HI [8] = '{4'd4, 4'd8, 4'd3, 4'd7, 4'd2, 4'd6, 4'd1, 4'd5};

  // sequencer states
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_WRITE = 9'b000000010,
    ST_SCAN  = 9'b000000100,
    ST_RANGE = 9'b000001000,
    ST_MUL   = 9'b000010000,
    ST_DIV   = 9'b000100000,
    ST_IMUL  = 9'b001000000,
    ST_IDIV  = 9'b010000000,
    ST_DONE  = 9'b100000000
  } sai_state_t;

endpackage

// File: src/sai_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies; holds the per-frame peak and floor history
module sai_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: src/spectrum_autorange_interpolator_core.sv
// spectrum autorange interpolator: history ring, range scan, mapping and interpolation
// depends on sai_pkg and sai_ram
//
//   channel | direction | tdata / data                    | tuser      | handshake
//   in_     | slave     | band_a..band_e, 12 bits each    | -          | in_tvalid/in_tready
//   out_    | master    | chan_0..chan_9, 12 bits each    | range_zero | out_tvalid/out_tready
//   cfg_    | slave     | full_scale, 12 bits             | -          | cfg_valid/cfg_ready
//
// a result follows its item through a ring write, a scan of all WINDOW_LEN slots through the
// history ram read port, a range check, for each of the 5 bands a multiply and a 12-step
// restoring division, for each of 16 ninths terms a weight multiply and a divide by nine on
// the shared multiplier, and the output load; the next item is accepted in the idle state
// after the load at the earliest. an empty range skips mapping and interpolation.
// in_tready is high only while idle; a finished item waits in the output register,
// and the next item is taken while it waits; a later result holds the sequencer in its
// output load cycle until that register is free. reset is synchronous, active low.
module spectrum_autorange_interpolator_core import sai_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // band_a, band_b, band_c, band_d, band_e, zero pad
  // result items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // chan_0 .. chan_9
  output logic [0:0]            out_tuser,  // range_zero
  // full scale register write
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CHAN_W-1:0]     cfg_data
);

  // control state
  sai_state_t state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [FILL_W-1:0] cnt_r, cnt_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [BIDX_W-1:0] bidx_r, bidx_nxt;
  logic [3:0]        term_r, term_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              rd_live_r, rd_live_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [CHAN_W-1:0] fs_r, fs_nxt;

  // datapath registers
  logic [BAND_W-1:0]     band_r [BAND_COUNT];
  logic [BAND_W-1:0]     band_nxt [BAND_COUNT];
  logic [BAND_W-1:0]     hi_r, hi_nxt, lo_r, lo_nxt, span_r, span_nxt;
  logic [BAND_W-1:0]     rem_r, rem_nxt;
  logic [CHAN_W-1:0]     qsh_r, qsh_nxt;
  logic [CHAN_W-1:0]     mapped_r [BAND_COUNT];
  logic [CHAN_W-1:0]     mapped_nxt [BAND_COUNT];
  logic [WPROD_W-1:0]    wprod_r, wprod_nxt;
  logic [CHAN_W-1:0]     acc_r, acc_nxt;
  logic [CHAN_W-1:0]     chan_r [CHAN_COUNT];
  logic [CHAN_W-1:0]     chan_nxt [CHAN_COUNT];
  logic                  zero_r, zero_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_zero_r, out_zero_nxt;

  // combinational helpers
  logic [FIELD_W-1:0]   field [BAND_COUNT];
  logic [BAND_W-1:0]    fmax, fmin;
  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_raddr;
  logic [HIST_W-1:0]    ram_wdata, ram_rdata;
  logic [BAND_W-1:0]    ent_pk, ent_fl;
  logic [BAND_W-1:0]    bsel, dlt;
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [2*MUL_W-1:0]   mul_p;
  logic [BAND_W:0]      trial;
  logic                 qbit;
  logic [BAND_W-1:0]    rem_step;
  logic [2:0]           tch;
  logic [BIDX_W-1:0]    tband;
  logic [3:0]           tweight;
  logic [CHAN_W-1:0]    tquot;
  logic [CIDX_W-1:0]    tcidx;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_zero_r;

  // unpack and mask the incoming bands
  always_comb begin
    for (int i = 0; i < BAND_COUNT; i++) begin
      field[i] = in_tdata[i*FIELD_W +: FIELD_W] & LEVEL_MASK;
    end
  end

  // frame maximum and minimum of the stored bands
  always_comb begin
    fmax = band_r[0];
    fmin = band_r[0];
    for (int i = 1; i < BAND_COUNT; i++) begin
      if (band_r[i] > fmax) fmax = band_r[i];
      if (band_r[i] < fmin) fmin = band_r[i];
    end
  end

  // history ring: peak in the upper half, floor in the lower half
  assign ram_we    = (state_r == ST_WRITE);
  assign ram_wdata = {fmax, fmin};
  assign ram_raddr = (cnt_r < FILL_W'(WINDOW_LEN)) ? cnt_r[SLOT_W-1:0] : '0;

  sai_ram #(
    .WIDTH (HIST_W),
    .DEPTH (WINDOW_LEN)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // slots not yet written since reset read as zero
  assign ent_pk = rd_live_r ? ram_rdata[HIST_W-1:BAND_W] : '0;
  assign ent_fl = rd_live_r ? ram_rdata[BAND_W-1:0]      : '0;

  // band offset above the window floor, clamped to the span
  always_comb begin
    bsel = band_r[bidx_r];
    dlt  = (bsel > lo_r) ? (bsel - lo_r) : '0;
    if (dlt > span_r) dlt = span_r;
  end

  // interpolation term selection
  assign tch     = term_r[3:1];
  assign tband   = BIDX_W'(term_r[3:2]) + BIDX_W'(term_r[0]);
  assign tweight = term_r[0] ? WT_HI[tch] : WT_LO[tch];
  assign tquot   = mul_p[RECIP_SHIFT +: CHAN_W];
  assign tcidx   = CIDX_W'(tch) + CIDX_W'(1);

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MUL: begin
        mul_a = MUL_W'(dlt);
        mul_b = MUL_W'(fs_r);
      end
      ST_IMUL: begin
        mul_a = MUL_W'(mapped_r[tband]);
        mul_b = MUL_W'(tweight);
      end
      ST_IDIV: begin
        mul_a = MUL_W'(wprod_r);
        mul_b = RECIP_9;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // one restoring division step
  always_comb begin
    trial    = {rem_r, qsh_r[CHAN_W-1]};
    qbit     = (trial >= {1'b0, span_r});
    rem_step = qbit ? BAND_W'(trial - {1'b0, span_r}) : trial[BAND_W-1:0];
  end

  // sequencer and next-state logic
  always_comb begin
    state_nxt      = state_r;
    slot_nxt       = slot_r;
    fill_nxt       = fill_r;
    cnt_nxt        = cnt_r;
    step_nxt       = step_r;
    bidx_nxt       = bidx_r;
    term_nxt       = term_r;
    rd_vld_nxt     = rd_vld_r;
    rd_live_nxt    = rd_live_r;
    out_tvalid_nxt = out_tvalid_r;
    fs_nxt         = fs_r;
    band_nxt       = band_r;
    hi_nxt         = hi_r;
    lo_nxt         = lo_r;
    span_nxt       = span_r;
    rem_nxt        = rem_r;
    qsh_nxt        = qsh_r;
    mapped_nxt     = mapped_r;
    wprod_nxt      = wprod_r;
    acc_nxt        = acc_r;
    chan_nxt       = chan_r;
    zero_nxt       = zero_r;
    out_data_nxt   = out_data_r;
    out_zero_nxt   = out_zero_r;

    // register write
    if (cfg_valid) fs_nxt = cfg_data;

    // result taken downstream
    if (out_tvalid_r && out_tready) out_tvalid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          band_nxt[0] = BAND_W'(field[0]) + BAND_W'(field[0] >> 1);
          for (int i = 1; i < BAND_COUNT; i++) begin
            band_nxt[i] = BAND_W'(field[i]);
          end
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        slot_nxt   = (slot_r == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_r + SLOT_W'(1);
        fill_nxt   = (fill_r == FILL_W'(WINDOW_LEN)) ? fill_r : fill_r + FILL_W'(1);
        cnt_nxt    = '0;
        rd_vld_nxt = 1'b0;
        hi_nxt     = '0;
        lo_nxt     = '1;
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        // fold in the entry read last cycle
        if (rd_vld_r) begin
          if (ent_pk > hi_r) hi_nxt = ent_pk;
          if (ent_fl < lo_r) lo_nxt = ent_fl;
        end
        if (cnt_r != FILL_W'(WINDOW_LEN)) begin
          cnt_nxt     = cnt_r + FILL_W'(1);
          rd_vld_nxt  = 1'b1;
          rd_live_nxt = (cnt_r < fill_r);
        end else begin
          rd_vld_nxt = 1'b0;
          state_nxt  = ST_RANGE;
        end
      end
      ST_RANGE: begin
        if (hi_r <= lo_r) begin
          zero_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          zero_nxt  = 1'b0;
          span_nxt  = hi_r - lo_r;
          bidx_nxt  = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        // quotient stays below 2^12, so the top bits start as the remainder
        rem_nxt   = mul_p[NUM_W-1:CHAN_W];
        qsh_nxt   = mul_p[CHAN_W-1:0];
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt  = rem_step;
        qsh_nxt  = {qsh_r[CHAN_W-2:0], qbit};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(CHAN_W - 1)) begin
          mapped_nxt[bidx_r] = {qsh_r[CHAN_W-2:0], qbit};
          if (bidx_r == BIDX_W'(BAND_COUNT - 1)) begin
            term_nxt  = '0;
            state_nxt = ST_IMUL;
          end else begin
            bidx_nxt  = bidx_r + BIDX_W'(1);
            state_nxt = ST_MUL;
          end
        end
      end
      ST_IMUL: begin
        wprod_nxt = mul_p[WPROD_W-1:0];
        state_nxt = ST_IDIV;
      end
      ST_IDIV: begin
        if (!term_r[0]) begin
          acc_nxt = tquot;
        end else begin
          chan_nxt[tcidx] = acc_r + tquot;
        end
        if (term_r == 4'd15) begin
          chan_nxt[0]              = mapped_r[0];
          chan_nxt[CHAN_COUNT - 1] = mapped_r[BAND_COUNT - 1];
          state_nxt                = ST_DONE;
        end else begin
          term_nxt  = term_r + 4'd1;
          state_nxt = ST_IMUL;
        end
      end
      ST_DONE: begin
        // load the output register once the previous item has left
        if (!out_tvalid_r || out_tready) begin
          out_data_nxt = '0;
          if (!zero_r) begin
            for (int i = 0; i < CHAN_COUNT; i++) begin
              out_data_nxt[i*CHAN_W +: CHAN_W] = chan_r[i];
            end
          end
          out_zero_nxt   = zero_r;
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slot_r       <= '0;
      fill_r       <= '0;
      cnt_r        <= '0;
      step_r       <= '0;
      bidx_r       <= '0;
      term_r       <= '0;
      rd_vld_r     <= 1'b0;
      rd_live_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
      fs_r         <= FS_RESET;
    end else begin
      state_r      <= state_nxt;
      slot_r       <= slot_nxt;
      fill_r       <= fill_nxt;
      cnt_r        <= cnt_nxt;
      step_r       <= step_nxt;
      bidx_r       <= bidx_nxt;
      term_r       <= term_nxt;
      rd_vld_r     <= rd_vld_nxt;
      rd_live_r    <= rd_live_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      fs_r         <= fs_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    band_r     <= band_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    span_r     <= span_nxt;
    rem_r      <= rem_nxt;
    qsh_r      <= qsh_nxt;
    mapped_r   <= mapped_nxt;
    wprod_r    <= wprod_nxt;
    acc_r      <= acc_nxt;
    chan_r     <= chan_nxt;
    zero_r     <= zero_nxt;
    out_data_r <= out_data_nxt;
    out_zero_r <= out_zero_nxt;
  end

endmodule

// File: src/sai_chk.sv
// port-level checker for the spectrum autorange interpolator core, bound to the top level
// depends on sai_pkg for the channel widths
module sai_chk import sai_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [0:0]            out_tuser
);

  // an accepted item keeps the block busy for the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted again right after an item");

  // a new result appears only as the sequencer returns to idle
  a_result_with_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result appeared while the block was still busy");

  // an empty range drives every channel to zero
  a_zero_range_channels: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0))
    else $error("empty range item carries nonzero channels");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind spectrum_autorange_interpolator_core sai_chk u_sai_chk (.*);
